FILE: hdl/c2s_pkg.sv
`timescale 1ns / 1ps
package c2s_pkg;

    localparam int GUARD  = 24;
    localparam int STAGES = 32;
    localparam int CW     = 35 + GUARD;
    localparam int ZW     = 36;
    localparam int MW     = 35;
    localparam int UW     = 25;
    localparam int SQW    = 64;

    localparam logic signed [ZW-1:0] PI_Q32     = 36'sd13493037704;
    localparam logic signed [ZW-1:0] TWO_PI_Q32 = 36'sd26986075408;
    localparam logic [27:0]          DEG_PER_RAD_Q22 = 28'd240315917;
    localparam logic [UW-1:0]        FULL_TURN    = 25'd23592960;
    localparam logic [UW-1:0]        QUARTER_TURN = 25'd5898240;

    typedef enum logic [2:0] {
        LON_CORDIC,
        LON_ZERO,
        LON_HALF,
        LON_QUARTER,
        LON_THREE_QUARTER
    } t_lon_kind;

    typedef enum logic [1:0] {
        LAT_CORDIC,
        LAT_ZERO,
        LAT_POLE_N,
        LAT_POLE_S
    } t_lat_kind;

    typedef struct packed {
        t_lon_kind          lon_kind;
        logic               x_neg;
        logic [31:0]        lon_a;
        logic signed [32:0] lon_b;
        logic signed [31:0] z;
    } t_side_a;

    typedef struct packed {
        t_lon_kind   lon_kind;
        logic        x_neg;
        t_lat_kind   lat_kind;
        logic [31:0] rad;
    } t_side_b;

    typedef struct packed {
        t_lon_kind   lon_kind;
        t_lat_kind   lat_kind;
        logic        lat_neg;
        logic [31:0] rad;
    } t_side_c;

    function automatic logic [63:0] f_term(input int unsigned e);
        logic [63:0] t;
        if (e > 62) begin
            t = 64'd0;
        end else begin
            t = 64'd1 << (62 - e);
        end
        return t;
    endfunction

    function automatic logic [ZW-1:0] f_atan_q32(input int unsigned i);
        logic [63:0] s;
        if (i == 0) begin
            return 36'd3373259426;
        end
        s = f_term(i);
        s = s - f_term(3 * i) / 64'd3;
        s = s + f_term(5 * i) / 64'd5;
        s = s - f_term(7 * i) / 64'd7;
        s = s + f_term(9 * i) / 64'd9;
        s = s - f_term(11 * i) / 64'd11;
        s = s + f_term(13 * i) / 64'd13;
        s = s - f_term(15 * i) / 64'd15;
        s = s + f_term(17 * i) / 64'd17;
        s = s - f_term(19 * i) / 64'd19;
        s = s + f_term(21 * i) / 64'd21;
        s = s - f_term(23 * i) / 64'd23;
        s = s + f_term(25 * i) / 64'd25;
        s = s - f_term(27 * i) / 64'd27;
        s = s + f_term(29 * i) / 64'd29;
        s = s - f_term(31 * i) / 64'd31;
        s = s + f_term(33 * i) / 64'd33;
        s = s - f_term(35 * i) / 64'd35;
        s = s + f_term(37 * i) / 64'd37;
        s = s - f_term(39 * i) / 64'd39;
        s = s + f_term(41 * i) / 64'd41;
        s = s - f_term(43 * i) / 64'd43;
        s = s + f_term(45 * i) / 64'd45;
        s = s - f_term(47 * i) / 64'd47;
        s = s + f_term(49 * i) / 64'd49;
        s = s - f_term(51 * i) / 64'd51;
        s = s + f_term(53 * i) / 64'd53;
        s = s - f_term(55 * i) / 64'd55;
        s = s + f_term(57 * i) / 64'd57;
        s = s - f_term(59 * i) / 64'd59;
        s = s + f_term(61 * i) / 64'd61;
        s = (s + (64'd1 << 29)) >> 30;
        return s[ZW-1:0];
    endfunction

endpackage

FILE: hdl/c2s_in_if.sv
`timescale 1ns / 1ps
interface c2s_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic signed [31:0] z_position;

    modport source (output valid, output x_position, output y_position, output z_position,
                    input ready);
    modport sink (input valid, input x_position, input y_position, input z_position,
                  output ready);
endinterface

FILE: hdl/c2s_out_if.sv
`timescale 1ns / 1ps
interface c2s_out_if;
    logic               valid;
    logic               ready;
    logic [24:0]        longitude;
    logic signed [23:0] latitude;
    logic [31:0]        radius;

    modport source (output valid, output longitude, output latitude, output radius,
                    input ready);
    modport sink (input valid, input longitude, input latitude, input radius,
                  output ready);
endinterface

FILE: hdl/cartesian_to_spherical.sv
`timescale 1ns / 1ps
// Cartesian to spherical converter. Takes one (x, y, z) word per cycle while
// not stalled and returns longitude, latitude and radius, fully pipelined with
// a single stall enable: registers for magnitudes, squares and sums, two
// parallel 32-cell square root chains, a rounding register, two parallel 32-cell
// CORDIC chains, an angle fix-up register, a registered degree conversion and
// the output register. The 32-cell chains set most of the latency; throughput is
// one word a cycle whenever the output side is taken or empty.
module cartesian_to_spherical
    import c2s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    c2s_in_if.sink    i_pos,
    c2s_out_if.source o_sph
);
    localparam int NV = 3 + STAGES + 1 + STAGES + 1 + 2 + 1;
    localparam int NA = 3 + STAGES;
    localparam int NB = 1 + STAGES;

    logic          en;
    logic [NV-1:0] r_vld;

    assign en          = !r_vld[NV-1] || o_sph.ready;
    assign i_pos.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_pos.valid};
        end
    end

    // magnitudes and side data
    t_side_a     n_sa;
    t_side_a     r_sa [NA];
    logic [31:0] n_ax, n_ay, n_az, r1_ax, r1_ay, r1_az;
    logic        x_zero, y_zero;

    always_comb begin
        n_ax   = i_pos.x_position[31] ? (~i_pos.x_position + 32'd1) : i_pos.x_position;
        n_ay   = i_pos.y_position[31] ? (~i_pos.y_position + 32'd1) : i_pos.y_position;
        n_az   = i_pos.z_position[31] ? (~i_pos.z_position + 32'd1) : i_pos.z_position;
        x_zero = (i_pos.x_position == '0);
        y_zero = (i_pos.y_position == '0);
        n_sa.x_neg = i_pos.x_position[31];
        n_sa.lon_a = n_ax;
        n_sa.lon_b = i_pos.x_position[31] ? -33'(i_pos.y_position) : 33'(i_pos.y_position);
        n_sa.z     = i_pos.z_position;
        if (x_zero && y_zero) begin
            n_sa.lon_kind = LON_ZERO;
        end else if (y_zero) begin
            n_sa.lon_kind = i_pos.x_position[31] ? LON_HALF : LON_ZERO;
        end else if (x_zero) begin
            n_sa.lon_kind = i_pos.y_position[31] ? LON_THREE_QUARTER : LON_QUARTER;
        end else begin
            n_sa.lon_kind = LON_CORDIC;
        end
    end

    logic [SQW-1:0] r2_sqx, r2_sqy, r2_sqz, r3_sxy, r3_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax  <= n_ax;
            r1_ay  <= n_ay;
            r1_az  <= n_az;
            r2_sqx <= r1_ax * r1_ax;
            r2_sqy <= r1_ay * r1_ay;
            r2_sqz <= r1_az * r1_az;
            r3_sxy <= r2_sqx + r2_sqy;
            r3_n   <= r2_sqx + r2_sqy + r2_sqz;
            r_sa[0] <= n_sa;
            for (int k = 1; k < NA; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // square root chains
    logic [SQW-1:0] xy_rem [STAGES+1];
    logic [SQW-1:0] xy_res [STAGES+1];
    logic [SQW-1:0] n_rem  [STAGES+1];
    logic [SQW-1:0] n_res  [STAGES+1];

    assign xy_rem[0] = r3_sxy;
    assign xy_res[0] = '0;
    assign n_rem[0]  = r3_n;
    assign n_res[0]  = '0;

    for (genvar k = 0; k < STAGES; k++) begin : g_sqrt
        c2s_sqrt_cell #(.POS(STAGES - 1 - k)) u_xy (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (xy_rem[k]),
            .i_res (xy_res[k]),
            .o_rem (xy_rem[k+1]),
            .o_res (xy_res[k+1])
        );
        c2s_sqrt_cell #(.POS(STAGES - 1 - k)) u_rad (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (n_rem[k]),
            .i_res (n_res[k]),
            .o_rem (n_rem[k+1]),
            .o_res (n_res[k+1])
        );
    end

    // rounding and CORDIC set-up
    logic [SQW-1:0] rxy_full, rad_full;
    t_side_a        sa_end;
    t_side_b        n_sb;
    t_side_b        r_sb [NB];

    logic signed [CW-1:0] r4_lon_a, r4_lon_b, r4_lat_a, r4_lat_b;

    always_comb begin
        sa_end   = r_sa[NA-1];
        rxy_full = xy_res[STAGES] + SQW'(xy_rem[STAGES] > xy_res[STAGES]);
        rad_full = n_res[STAGES] + SQW'(n_rem[STAGES] > n_res[STAGES]);
        n_sb.lon_kind = sa_end.lon_kind;
        n_sb.x_neg    = sa_end.x_neg;
        n_sb.rad      = rad_full[31:0];
        if (sa_end.z == '0) begin
            n_sb.lat_kind = LAT_ZERO;
        end else if (rxy_full[31:0] == '0) begin
            n_sb.lat_kind = sa_end.z[31] ? LAT_POLE_S : LAT_POLE_N;
        end else begin
            n_sb.lat_kind = LAT_CORDIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_lon_a <= {3'b000, sa_end.lon_a, {GUARD{1'b0}}};
            r4_lon_b <= {{2{sa_end.lon_b[32]}}, sa_end.lon_b, {GUARD{1'b0}}};
            r4_lat_a <= {3'b000, rxy_full[31:0], {GUARD{1'b0}}};
            r4_lat_b <= {{3{sa_end.z[31]}}, sa_end.z, {GUARD{1'b0}}};
            r_sb[0]  <= n_sb;
            for (int k = 1; k < NB; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // CORDIC chains
    logic signed [CW-1:0] lon_a [STAGES+1];
    logic signed [CW-1:0] lon_b [STAGES+1];
    logic signed [ZW-1:0] lon_z [STAGES+1];
    logic signed [CW-1:0] lat_a [STAGES+1];
    logic signed [CW-1:0] lat_b [STAGES+1];
    logic signed [ZW-1:0] lat_z [STAGES+1];

    assign lon_a[0] = r4_lon_a;
    assign lon_b[0] = r4_lon_b;
    assign lon_z[0] = '0;
    assign lat_a[0] = r4_lat_a;
    assign lat_b[0] = r4_lat_b;
    assign lat_z[0] = '0;

    for (genvar k = 0; k < STAGES; k++) begin : g_cordic
        c2s_cordic_cell #(.IDX(k)) u_lon (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (lon_a[k]),
            .i_b   (lon_b[k]),
            .i_z   (lon_z[k]),
            .o_a   (lon_a[k+1]),
            .o_b   (lon_b[k+1]),
            .o_z   (lon_z[k+1])
        );
        c2s_cordic_cell #(.IDX(k)) u_lat (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (lat_a[k]),
            .i_b   (lat_b[k]),
            .i_z   (lat_z[k]),
            .o_a   (lat_a[k+1]),
            .o_b   (lat_b[k+1]),
            .o_z   (lat_z[k+1])
        );
    end

    // angle fix-up
    t_side_b              sb_end;
    t_side_c              n_sc;
    t_side_c              r_sc [3];
    logic signed [ZW-1:0] lon_ang, lon_wrap, lat_ang;
    logic [MW-1:0]        n_lon_m, n_lat_m, r5_lon_m, r5_lat_m;

    always_comb begin
        sb_end   = r_sb[NB-1];
        lon_ang  = lon_z[STAGES] + (sb_end.x_neg ? PI_Q32 : ZW'(0));
        lon_wrap = lon_ang[ZW-1] ? lon_ang + TWO_PI_Q32 : lon_ang;
        n_lon_m  = lon_wrap[MW-1:0];
        lat_ang  = lat_z[STAGES];
        n_lat_m  = lat_ang[ZW-1] ? MW'(-lat_ang) : lat_ang[MW-1:0];
        n_sc.lon_kind = sb_end.lon_kind;
        n_sc.lat_kind = sb_end.lat_kind;
        n_sc.lat_neg  = lat_ang[ZW-1];
        n_sc.rad      = sb_end.rad;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_lon_m <= n_lon_m;
            r5_lat_m <= n_lat_m;
            r_sc[0]  <= n_sc;
            r_sc[1]  <= r_sc[0];
            r_sc[2]  <= r_sc[1];
        end
    end

    logic [UW-1:0] lon_units, lat_units;

    c2s_conv u_lon_conv (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag   (r5_lon_m),
        .o_units (lon_units)
    );

    c2s_conv u_lat_conv (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag   (r5_lat_m),
        .o_units (lat_units)
    );

    // output register
    t_side_c            sc_end;
    logic [UW-1:0]      n_lon, lat_clamp;
    logic signed [23:0] n_lat;
    logic [UW-1:0]      r_lon;
    logic signed [23:0] r_lat;
    logic [31:0]        r_rad;

    always_comb begin
        sc_end = r_sc[2];
        case (sc_end.lon_kind)
            LON_CORDIC:        n_lon = (lon_units >= FULL_TURN) ? lon_units - FULL_TURN
                                                                : lon_units;
            LON_ZERO:          n_lon = '0;
            LON_HALF:          n_lon = QUARTER_TURN << 1;
            LON_QUARTER:       n_lon = QUARTER_TURN;
            LON_THREE_QUARTER: n_lon = (QUARTER_TURN << 1) + QUARTER_TURN;
            default:           n_lon = '0;
        endcase
        lat_clamp = (lat_units > QUARTER_TURN) ? QUARTER_TURN : lat_units;
        case (sc_end.lat_kind)
            LAT_CORDIC: n_lat = sc_end.lat_neg ? -lat_clamp[23:0] : lat_clamp[23:0];
            LAT_ZERO:   n_lat = '0;
            LAT_POLE_N: n_lat = QUARTER_TURN[23:0];
            LAT_POLE_S: n_lat = -QUARTER_TURN[23:0];
            default:    n_lat = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lon <= n_lon;
            r_lat <= n_lat;
            r_rad <= sc_end.rad;
        end
    end

    assign o_sph.valid     = r_vld[NV-1];
    assign o_sph.longitude = r_lon;
    assign o_sph.latitude  = r_lat;
    assign o_sph.radius    = r_rad;
endmodule

FILE: hdl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
module c2s_sqrt_cell
    import c2s_pkg::*;
#(
    parameter int POS = 31
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [SQW-1:0] i_rem,
    input  logic [SQW-1:0] i_res,
    output logic [SQW-1:0] o_rem,
    output logic [SQW-1:0] o_res
);
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * POS);

    logic [SQW-1:0] r_rem, r_res;
    logic [SQW-1:0] n_rem, n_res, trial;

    always_comb begin
        trial = i_res + BIT;
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;
endmodule

FILE: hdl/c2s_cordic_cell.sv
`timescale 1ns / 1ps
module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0] o_a,
    output logic signed [CW-1:0] o_b,
    output logic signed [ZW-1:0] o_z
);
    localparam logic signed [ZW-1:0] STEP = f_atan_q32(IDX);

    logic signed [CW-1:0] r_a, r_b, n_a, n_b, da, db;
    logic signed [ZW-1:0] r_z, n_z;

    always_comb begin
        da = i_b >>> IDX;
        db = i_a >>> IDX;
        if (!i_b[CW-1]) begin
            n_a = i_a + da;
            n_b = i_b - db;
            n_z = i_z + STEP;
        end else begin
            n_a = i_a - da;
            n_b = i_b + db;
            n_z = i_z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_z <= n_z;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_z = r_z;
endmodule

FILE: hdl/c2s_conv.sv
`timescale 1ns / 1ps
module c2s_conv
    import c2s_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_mag,
    output logic [UW-1:0] o_units
);
    logic [44:0]   r_p_hi;
    logic [45:0]   r_p_lo;
    logic [UW-1:0] r_units;
    logic [63:0]   n_sum;

    assign n_sum = {1'b0, r_p_hi, 18'd0} + 64'(r_p_lo) + (64'd1 << 37);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hi  <= i_mag[MW-1:18] * DEG_PER_RAD_Q22;
            r_p_lo  <= i_mag[17:0] * DEG_PER_RAD_Q22;
            r_units <= n_sum[62:38];
        end
    end

    assign o_units = r_units;
endmodule

FILE: hdl/c2s_checker.sv
`timescale 1ns / 1ps
module c2s_checker
    import c2s_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [24:0]        i_longitude,
    input logic signed [23:0] i_latitude,
    input logic [31:0]        i_radius
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_longitude)
            && $stable(i_latitude) && $stable(i_radius))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_lon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_longitude < FULL_TURN)
        else $error("longitude out of range");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_latitude <= $signed({1'b0, QUARTER_TURN[22:0]}))
            && (i_latitude >= -$signed({1'b0, QUARTER_TURN[22:0]})))
        else $error("latitude out of range");
endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pos.ready),
    .i_out_valid (o_sph.valid),
    .i_out_ready (o_sph.ready),
    .i_longitude (o_sph.longitude),
    .i_latitude  (o_sph.latitude),
    .i_radius    (o_sph.radius)
);

FILE: dv/cartesian_to_spherical_tb.sv
`timescale 1ns / 1ps
module cartesian_to_spherical_tb;
    import c2s_pkg::*;

    typedef struct {
        logic [24:0]        lon;
        logic signed [23:0] lat;
        logic [31:0]        rad;
    } t_sph;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 known;
        t_sph               res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    c2s_in_if  pos_if();
    c2s_out_if sph_if();

    cartesian_to_spherical DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos_if.sink),
        .o_sph   (sph_if.source)
    );

    t_sph   sph_due[$];
    t_sph   sph_known[$];
    bit     known_due[$];
    int     errors;
    int     words_out;
    int     send_idle;
    int     take_idle;
    int     hold_off;
    longint atan_lut[STAGES];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint unsigned acc;
        longint unsigned t;
        int k;
        int e;
        acc = 0;
        if (i == 0) return 64'd3373259426;
        for (k = 0; k < 40; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) break;
            t = (64'd1 << (62 - e)) / longint'(2 * k + 1);
            if (k % 2) acc -= t;
            else acc += t;
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint vector_angle(longint a, longint b);
        longint ang;
        longint da;
        longint db;
        ang = 0;
        a = a <<< GUARD;
        b = b <<< GUARD;
        for (int i = 0; i < STAGES; i++) begin
            da = shr_floor(b, i);
            db = shr_floor(a, i);
            if (b >= 0) begin
                a += da; b -= db; ang += atan_lut[i];
            end else begin
                a -= da; b += db; ang -= atan_lut[i];
            end
        end
        return ang;
    endfunction

    function automatic longint to_deg_units(longint r);
        longint unsigned m;
        longint d;
        m = (r < 0) ? -r : r;
        d = longint'((m * 64'd240315917 + (64'd1 << 37)) >> 38);
        return (r < 0) ? -d : d;
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = n;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (res * res + res < n) res++;
        return res;
    endfunction

    function automatic t_sph spherical_of(logic signed [31:0] xi, logic signed [31:0] yi,
                                          logic signed [31:0] zi);
        longint x;
        longint y;
        longint z;
        longint unsigned sxy;
        longint unsigned rxy;
        longint unsigned rad;
        longint lon;
        longint lat;
        longint ang;
        longint quarter;
        longint full;
        t_sph s;
        quarter = QUARTER_TURN;
        full = FULL_TURN;
        x = xi;
        y = yi;
        z = zi;
        sxy = longint'(x * x) + longint'(y * y);
        rxy = root_nearest(sxy);
        rad = root_nearest(sxy + longint'(z * z));
        if (x == 0 && y == 0) lon = 0;
        else if (y == 0) lon = (x > 0) ? 0 : 2 * quarter;
        else if (x == 0) lon = (y > 0) ? quarter : 3 * quarter;
        else begin
            ang = (x < 0) ? vector_angle(-x, -y) + PI_Q32 : vector_angle(x, y);
            if (ang < 0) ang += TWO_PI_Q32;
            lon = to_deg_units(ang);
            if (lon >= full) lon -= full;
            if (lon < 0) lon = 0;
        end
        if (z == 0) lat = 0;
        else if (rxy == 0) lat = (z > 0) ? quarter : -quarter;
        else begin
            lat = to_deg_units(vector_angle(longint'(rxy), z));
            if (lat > quarter) lat = quarter;
            if (lat < -quarter) lat = -quarter;
        end
        if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
        s.lon = lon[24:0];
        s.lat = lat[23:0];
        s.rad = rad[31:0];
        return s;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom_range(0, 255) - 128;
            4, 5:    return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit known, t_sph res);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            pos_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sph_due.push_back(spherical_of(x, y, z));
        known_due.push_back(known);
        sph_known.push_back(res);
        pos_if.valid      <= 1'b1;
        pos_if.x_position <= x;
        pos_if.y_position <= y;
        pos_if.z_position <= z;
        do @(posedge i_clk); while (!pos_if.ready);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sph_due.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        sph_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                sph_if.ready <= 1'b0;
                hold_off--;
            end else begin
                sph_if.ready <= ($urandom_range(0, 99) >= take_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sph e;
        t_sph k;
        bit   has_known;
        if (i_rst_n && sph_if.valid && sph_if.ready) begin
            words_out++;
            if (sph_due.size() == 0) begin
                $display("%0t: unexpected word lon=%0d lat=%0d rad=%0d", $time,
                         sph_if.longitude, sph_if.latitude, sph_if.radius);
                errors++;
            end else begin
                e = sph_due.pop_front();
                k = sph_known.pop_front();
                has_known = known_due.pop_front();
                if (has_known && (k.lon !== e.lon || k.lat !== e.lat || k.rad !== e.rad)) begin
                    $display("%0t: table row disagrees with predictor", $time);
                    errors++;
                end
                if (sph_if.longitude !== e.lon) begin
                    $display("%0t: longitude expected %0d actual %0d", $time,
                             e.lon, sph_if.longitude);
                    errors++;
                end
                if (sph_if.latitude !== e.lat) begin
                    $display("%0t: latitude expected %0d actual %0d", $time,
                             e.lat, sph_if.latitude);
                    errors++;
                end
                if (sph_if.radius !== e.rad) begin
                    $display("%0t: radius expected %0d actual %0d", $time,
                             e.rad, sph_if.radius);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_sph none;
        int   n;
        none = '{0, 0, 0};
        errors = 0;
        words_out = 0;
        hold_off = 0;
        send_idle = 12;
        take_idle = 54;
        for (int i = 0; i < STAGES; i++) atan_lut[i] = atan_entry(i);
        pos_if.valid      <= 1'b0;
        pos_if.x_position <= '0;
        pos_if.y_position <= '0;
        pos_if.z_position <= '0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{0, 0, 0, 1, '{0, 0, 0}},
            '{0, 0, 32'sd65536, 1, '{0, 24'sd5898240, 32'd65536}},
            '{0, 0, -32'sd65536, 1, '{0, -24'sd5898240, 32'd65536}},
            '{32'sd65536, 0, 0, 1, '{0, 0, 32'd65536}},
            '{-32'sd65536, 0, 0, 1, '{25'd11796480, 0, 32'd65536}},
            '{0, 32'sd65536, 0, 1, '{25'd5898240, 0, 32'd65536}},
            '{0, -32'sd65536, 0, 1, '{25'd17694720, 0, 32'd65536}},
            '{32'sh7FFF_FFFF, 0, 0, 1, '{0, 0, 32'h7FFF_FFFF}},
            '{32'sh8000_0000, 0, 0, 1, '{25'd11796480, 0, 32'h8000_0000}},
            '{0, 0, 32'sh8000_0000, 1, '{0, -24'sd5898240, 32'h8000_0000}},
            '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, none},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, none},
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, none},
            '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, none},
            '{32'sd65536, 32'sd65536, 32'sd65536, 0, none},
            '{-32'sd65536, 32'sd65536, -32'sd1, 0, none},
            '{-32'sd65536, -32'sd1, 32'sd1, 0, none},
            '{32'sd1, -32'sd65536, 32'sd3, 0, none},
            '{-32'sd1, -32'sd1, -32'sd1, 0, none},
            '{32'sd1, 32'sd1, 0, 0, none},
            '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 0, none}
        };
        foreach (rows[r]) send_word(rows[r].x, rows[r].y, rows[r].z, rows[r].known, rows[r].res);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle = 54;
                take_idle = 12;
            end else if (phase == 2) begin
                send_idle = 0;
                take_idle = 0;
                hold_off = 300;
            end
            for (n = 0; n < 260; n++) send_word(rand_coord(), rand_coord(), rand_coord(), 0, none);
            pos_if.valid <= 1'b0;
            drain();
        end
        repeat (150) @(posedge i_clk);

        $display("Converted %0d positions: axes, poles, origin, full-scale corners, random",
                 words_out);
        $display("coordinates under sender and receiver stalls and one long output hold.");
        if (errors == 0 && sph_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
